[hdl/dotq_pkg.sv]
// Shared types and codes for the deadline-ordered task queue.
// No dependencies; used by the controller, the datapath and the top level.
package dotq_pkg;

   localparam int KEY_W    = 32;
   localparam int TASK_W   = 4;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // operation codes on the request kind field
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   // status codes on the response
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic              kind;
      logic [KEY_W-1:0]  event_key;
      logic [TASK_W-1:0] task_number;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0]   popped_task;
      logic [KEY_W-1:0]    popped_key;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic insert;   // place the request entry in key order
      logic pop;      // shift all slots one place toward the head
      logic capture;  // load the popped-entry response register
   } cmd_type;

endpackage

[hdl/dotq_ctrl.sv]
// Controller for the deadline-ordered task queue: handshake state machine,
// entry count, status and occupancy of the response. Uses dotq_pkg.
module dotq_ctrl #(
   parameter int DEPTH = 16,
   parameter int CW    = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dotq_pkg::cmd_type             cmd,
   output logic [CW-1:0]                 count,
   output logic [dotq_pkg::STATUS_W-1:0] status,
   output logic [dotq_pkg::OCC_W-1:0]    occupancy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [dotq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [dotq_pkg::OCC_W-1:0]    occ_ff, occ_in;
   logic                          accept;
   logic                          empty;
   logic                          full;

   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));

   always_comb begin
      count_in    = count_ff;
      status_in   = status_ff;
      occ_in      = occ_ff;
      cmd.insert  = 1'b0;
      cmd.pop     = 1'b0;
      cmd.capture = accept;
      if (accept) begin
         status_in = dotq_pkg::STATUS_DONE;
         if (req_kind == dotq_pkg::KIND_POP) begin
            if (empty) begin
               status_in = dotq_pkg::STATUS_EMPTY;
            end else begin
               cmd.pop  = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end else begin
            if (full) begin
               status_in = dotq_pkg::STATUS_FULL;
            end else begin
               cmd.insert = 1'b1;
               count_in   = count_ff + CW'(1);
            end
         end
         occ_in = dotq_pkg::OCC_W'(count_in);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready && !accept) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      occ_ff    <= occ_in;
   end

   assign rsp_valid = (state_ff == ST_HOLD);
   assign count     = count_ff;
   assign status    = status_ff;
   assign occupancy = occ_ff;

endmodule

[hdl/dotq_datapath.sv]
// Datapath for the deadline-ordered task queue: a row of sorted slots, each
// comparing its key with the new one, plus the popped-entry register. Uses dotq_pkg.
module dotq_datapath #(
   parameter int DEPTH = 16,
   parameter int CW    = 5
) (
   input  logic                        clock,
   input  dotq_pkg::cmd_type           cmd,
   input  logic [CW-1:0]               count,
   input  logic [dotq_pkg::KEY_W-1:0]  new_key,
   input  logic [dotq_pkg::TASK_W-1:0] new_task,
   output logic [dotq_pkg::TASK_W-1:0] popped_task,
   output logic [dotq_pkg::KEY_W-1:0]  popped_key
);

   logic [dotq_pkg::KEY_W-1:0]  key_ff  [DEPTH];
   logic [dotq_pkg::KEY_W-1:0]  key_in  [DEPTH];
   logic [dotq_pkg::TASK_W-1:0] task_ff [DEPTH];
   logic [dotq_pkg::TASK_W-1:0] task_in [DEPTH];
   logic [DEPTH-1:0]            stay;     // slot sits ahead of the new entry
   logic [dotq_pkg::TASK_W-1:0] ptask_ff, ptask_in;
   logic [dotq_pkg::KEY_W-1:0]  pkey_ff, pkey_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      logic held;
      assign held = (CW'(i) < count);

      // An equal head key keeps the head in place; deeper slots stay only if smaller.
      if (i == 0) begin : g_head
         assign stay[i] = held && (key_ff[i] <= new_key);
      end else begin : g_body
         assign stay[i] = held && (key_ff[i] < new_key);
      end

      always_comb begin
         key_in[i]  = key_ff[i];
         task_in[i] = task_ff[i];
         if (cmd.insert && !stay[i]) begin
            if (i == 0) begin
               key_in[i]  = new_key;
               task_in[i] = new_task;
            end else if (stay[(i == 0) ? 0 : i-1]) begin
               key_in[i]  = new_key;
               task_in[i] = new_task;
            end else begin
               key_in[i]  = key_ff[(i == 0) ? 0 : i-1];
               task_in[i] = task_ff[(i == 0) ? 0 : i-1];
            end
         end else if (cmd.pop && (i < DEPTH-1)) begin
            key_in[i]  = key_ff[(i < DEPTH-1) ? i+1 : i];
            task_in[i] = task_ff[(i < DEPTH-1) ? i+1 : i];
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i]  <= key_in[i];
         task_ff[i] <= task_in[i];
      end
   end

   always_comb begin
      ptask_in = ptask_ff;
      pkey_in  = pkey_ff;
      if (cmd.capture) begin
         ptask_in = cmd.pop ? task_ff[0] : '0;
         pkey_in  = cmd.pop ? key_ff[0]  : '0;
      end
   end

   always_ff @(posedge clock) begin
      ptask_ff <= ptask_in;
      pkey_ff  <= pkey_in;
   end

   assign popped_task = ptask_ff;
   assign popped_key  = pkey_ff;

endmodule

[hdl/deadline_ordered_task_queue.sv]
// Deadline-ordered task queue: sorted priority queue of task numbers by event key.
// Instantiates dotq_ctrl and dotq_datapath; uses dotq_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one operation per item:
//   kind insert places (event_key, task_number) in ascending key order, an
//   entry with a key equal to the head going just behind it; kind pop removes
//   the head. Each request item yields exactly one rsp item (rsp_valid/
//   rsp_ready/rsp_data) with the popped entry (zero unless a pop succeeded),
//   a status (done, pop on empty, insert on full) and the occupancy after it.
//   The response is registered at the accepting edge. Throughput is one item
//   per cycle; every slot compares its key with the new key in parallel and
//   shifts in the same cycle, so the slot row sets the figure. req_ready stays
//   high while rsp_ready is high or no response is held; a stalled response
//   holds and blocks only further requests. Reset (synchronous, active high)
//   empties the queue and drops any held response; slot contents are not
//   cleared.
module deadline_ordered_task_queue #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dotq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dotq_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   dotq_pkg::cmd_type             cmd;
   logic [CW-1:0]                 count;
   logic [dotq_pkg::STATUS_W-1:0] status;
   logic [dotq_pkg::OCC_W-1:0]    occupancy;
   logic [dotq_pkg::TASK_W-1:0]   popped_task;
   logic [dotq_pkg::KEY_W-1:0]    popped_key;

   dotq_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .count     (count),
      .status    (status),
      .occupancy (occupancy)
   );

   dotq_datapath #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .count       (count),
      .new_key     (req_data.event_key),
      .new_task    (req_data.task_number),
      .popped_task (popped_task),
      .popped_key  (popped_key)
   );

   assign rsp_data.popped_task = popped_task;
   assign rsp_data.popped_key  = popped_key;
   assign rsp_data.status      = status;
   assign rsp_data.occupancy   = occupancy;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> count == $past(count) - CW'(1))
      else $error("pop did not drop the entry count by one");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count == $past(count) + CW'(1))
      else $error("insert did not raise the entry count by one");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == dotq_pkg::STATUS_FULL) |-> count == CW'(DEPTH))
      else $error("full status reported while queue not full");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.pop) && (!(cmd.insert || cmd.pop) || cmd.capture))
      else $error("conflicting datapath commands");
`endif

endmodule
